// ----- rtl/core/gfsw_pkg.sv -----
// shared constants and types for the gray framebuffer span writer
// no dependencies; imported by gfsw_store and the top level
`default_nettype none

package gfsw_pkg;

    // store geometry
    localparam int COLUMNS     = 128;
    localparam int ROWS        = 64;
    localparam int STORE_BYTES = COLUMNS * ROWS;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    // packing constants
    localparam logic [7:0] MASK_MSB = 8'h80;
    localparam logic [7:0] NIB_HI   = 8'hf0;
    localparam logic [7:0] NIB_LO   = 8'h0f;

    // transaction function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // packing format codes
    localparam logic FMT_1BIT = 1'b0;
    localparam logic FMT_4BIT = 1'b1;

    // one access to the frame store
    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } store_req_t;

endpackage : gfsw_pkg

`default_nettype wire

// ----- rtl/core/gfsw_store.sv -----
// single-port frame store with registered read data and a clearing sweep after reset
// depends on gfsw_pkg
`default_nettype none

module gfsw_store
    import gfsw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire store_req_t req,
    output logic [7:0]      rdata,
    output logic            clear_busy
);

    logic [7:0]        mem [STORE_BYTES];
    logic [7:0]        rdata_reg;
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    // sweep counter, one entry a cycle
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            if (clr_addr_reg == ADDR_W'(STORE_BYTES - 1)) begin
                clr_busy_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // memory port: sweep has priority, read data registered
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (req.en && req.we) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.en && !req.we) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata      = rdata_reg;
    assign clear_busy = clr_busy_reg;

endmodule : gfsw_store

`default_nettype wire

// ----- rtl/core/gray_framebuffer_span_writer_core.sv -----
// Gray framebuffer span writer: span painting and byte readback on a packed frame store.
//
// Input channel (s_*): one transaction is either a span write (s_func = 0) that paints
// up to eight pixels of row s_span_y from column s_span_x, or a byte read (s_func = 1).
// Output channel (m_*): one transaction per byte read, carrying m_read_data; span writes
// give no output transaction.
// Timing: the block handles one input transaction at a time. A read fetches its byte
// into the store's read register and moves it into the output register once the output
// register is free; only then can the next transaction be accepted. A span write walks
// its eight pixel slots; a slot that paints a pixel reads the byte in ST_LOOK, then
// writes it back modified in ST_MODIFY on the single store port, a slot that paints
// nothing only passes ST_LOOK, and the next transaction is accepted after the walk.
// Reset (aresetn low, synchronous): a clearing sweep zeroes all 8192 store bytes, one a
// cycle; s_ready stays low until the sweep ends after reset is released.
// Stall: the result sits in an output register; while m_ready is low the block still
// takes new transactions, and a later read waits with its byte held until the register
// frees.
// Depends on gfsw_pkg and gfsw_store.
`default_nettype none

module gray_framebuffer_span_writer_core
    import gfsw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_func,
    input  wire logic       s_pack_format,
    input  wire logic [8:0] s_span_x,
    input  wire logic [8:0] s_span_y,
    input  wire logic [7:0] s_pattern_bits,
    input  wire logic [3:0] s_pixel_count,
    input  wire logic [3:0] s_fg_level,
    input  wire logic [3:0] s_bg_level,
    input  wire logic       s_opaque,
    input  wire logic [12:0] s_read_address,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_read_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOK   = 4'b0010,
        ST_MODIFY = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        pix_reg, pix_next;
    logic              fmt_reg;
    logic [8:0]        x0_reg;
    logic [8:0]        y_reg;
    logic [7:0]        pat_reg;
    logic [3:0]        cnt_reg;
    logic [3:0]        fg_reg;
    logic [3:0]        bg_reg;
    logic              opq_reg;
    logic              rd_ok_reg, rd_ok_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0]        mask_reg, mask_next;
    logic [3:0]        level_reg, level_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_data_reg, m_data_next;

    store_req_t        req;
    logic [7:0]        rdata;
    logic              clear_busy;

    logic              accept;
    logic [3:0]        cnt_sat;
    logic [9:0]        x_sum;
    logic              pat_set;
    logic              pix_active;
    logic [9:0]        cb;
    logic [8:0]        rb;
    logic              in_range;
    logic [19:0]       idx_wide;
    logic [2:0]        bit_sel;
    logic [7:0]        new_byte;
    logic              out_free;
    logic              rd_in_range;

    gfsw_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .rdata      (rdata),
        .clear_busy (clear_busy)
    );

    assign s_ready  = (state_reg == ST_IDLE) && !clear_busy;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_in_range = {1'b0, s_read_address} < 14'(STORE_BYTES);

    // pixel slot decode: column, row byte, range check and address
    always_comb begin
        cnt_sat    = (cnt_reg > 4'd8) ? 4'd8 : cnt_reg;
        x_sum      = {1'b0, x0_reg} + {7'd0, pix_reg};
        pat_set    = pat_reg[3'd7 - pix_reg];
        pix_active = ({1'b0, pix_reg} < cnt_sat) && (pat_set || opq_reg);
        if (fmt_reg == FMT_4BIT) begin
            cb = x_sum;
            rb = {1'b0, y_reg[8:1]};
        end else begin
            cb = {1'b0, x_sum[9:1]};
            rb = {2'b00, y_reg[8:2]};
        end
        in_range = (cb < 10'(COLUMNS)) && (rb < 9'(ROWS));
        idx_wide = 20'(cb) * 20'(ROWS) + 20'(rb);
        bit_sel  = {y_reg[1:0], x_sum[0]};
    end

    // byte update from the fetched value
    always_comb begin
        if (fmt_reg == FMT_4BIT) begin
            if (y_reg[0]) begin
                new_byte = (rdata & NIB_HI) | {4'd0, level_reg};
            end else begin
                new_byte = (rdata & NIB_LO) | {level_reg, 4'd0};
            end
        end else if (level_reg[0]) begin
            new_byte = rdata | mask_reg;
        end else begin
            new_byte = rdata & ~mask_reg;
        end
    end

    // sequencer and store port
    always_comb begin
        state_next   = state_reg;
        pix_next     = pix_reg;
        rd_ok_next   = rd_ok_reg;
        addr_next    = addr_reg;
        mask_next    = mask_reg;
        level_next   = level_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        req          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_func == FUNC_READ) begin
                        rd_ok_next = rd_in_range;
                        req.en     = rd_in_range;
                        req.addr   = ADDR_W'(s_read_address);
                        state_next = ST_RESULT;
                    end else begin
                        pix_next   = 3'd0;
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                if (pix_active && in_range) begin
                    addr_next  = idx_wide[ADDR_W-1:0];
                    mask_next  = MASK_MSB >> bit_sel;
                    level_next = pat_set ? fg_reg : bg_reg;
                    req.en     = 1'b1;
                    req.addr   = idx_wide[ADDR_W-1:0];
                    state_next = ST_MODIFY;
                end else if (pix_reg == 3'd7) begin
                    state_next = ST_IDLE;
                end else begin
                    pix_next = pix_reg + 3'd1;
                end
            end
            ST_MODIFY: begin
                req.en    = 1'b1;
                req.we    = 1'b1;
                req.addr  = addr_reg;
                req.wdata = new_byte;
                if (pix_reg == 3'd7) begin
                    state_next = ST_IDLE;
                end else begin
                    pix_next   = pix_reg + 3'd1;
                    state_next = ST_LOOK;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = rd_ok_reg ? rdata : 8'd0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pix_reg    <= pix_next;
        rd_ok_reg  <= rd_ok_next;
        addr_reg   <= addr_next;
        mask_reg   <= mask_next;
        level_reg  <= level_next;
        m_data_reg <= m_data_next;
        if (accept) begin
            fmt_reg <= s_pack_format;
            x0_reg  <= s_span_x;
            y_reg   <= s_span_y;
            pat_reg <= s_pattern_bits;
            cnt_reg <= s_pixel_count;
            fg_reg  <= s_fg_level;
            bg_reg  <= s_bg_level;
            opq_reg <= s_opaque;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_data_reg;

endmodule : gray_framebuffer_span_writer_core

`default_nettype wire

// ----- bench/gray_framebuffer_span_writer_core_test.sv -----
// self-checking testbench for gray_framebuffer_span_writer_core: spans and byte reads
// checked against a behavioural model of the packed frame store, under several idle mixes
// depends on gfsw_pkg and the core rtl only
module gray_framebuffer_span_writer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gfsw_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOT_DEPTH     = 48;
    localparam int PHASE_ITEMS   = 350;

    // one input transaction
    typedef struct {
        logic        func;
        logic        pack_format;
        logic [8:0]  span_x;
        logic [8:0]  span_y;
        logic [7:0]  pattern_bits;
        logic [3:0]  pixel_count;
        logic [3:0]  fg_level;
        logic [3:0]  bg_level;
        logic        opaque;
        logic [12:0] read_address;
    } span_request_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic        s_func         = FUNC_WRITE;
    logic        s_pack_format  = FMT_1BIT;
    logic [8:0]  s_span_x       = '0;
    logic [8:0]  s_span_y       = '0;
    logic [7:0]  s_pattern_bits = '0;
    logic [3:0]  s_pixel_count  = '0;
    logic [3:0]  s_fg_level     = '0;
    logic [3:0]  s_bg_level     = '0;
    logic        s_opaque       = 1'b0;
    logic [12:0] s_read_address = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [7:0]  m_read_data;

    // model of the frame store and the bytes still owed by the block
    logic [7:0]  frame_model [STORE_BYTES];
    logic [7:0]  expected_bytes [$];
    int unsigned touched_bytes [$];
    logic [7:0]  want_byte;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    gray_framebuffer_span_writer_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_pack_format  (s_pack_format),
        .s_span_x       (s_span_x),
        .s_span_y       (s_span_y),
        .s_pattern_bits (s_pattern_bits),
        .s_pixel_count  (s_pixel_count),
        .s_fg_level     (s_fg_level),
        .s_bg_level     (s_bg_level),
        .s_opaque       (s_opaque),
        .s_read_address (s_read_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data)
    );

    always #2 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // compare each result transaction with the oldest owed byte
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $error("read_data: no transaction expected, actual 0x%02h", m_read_data);
                error_count++;
            end else begin
                want_byte = expected_bytes.pop_front();
                if (m_read_data !== want_byte) begin
                    $error("read_data: expected 0x%02h, actual 0x%02h", want_byte,
                           m_read_data);
                    error_count++;
                end
            end
        end
    end

    // paint a span into the model store, noting the bytes it reaches
    function automatic void paint_span(input span_request_t it);
        int unsigned n_pix, px, py, lvl, idx;
        logic [7:0]  mask;
        bit          hit;
        n_pix = (it.pixel_count > 4'd8) ? 8 : it.pixel_count;
        py    = it.span_y;
        for (int i = 0; i < n_pix; i++) begin
            px = it.span_x + i;
            if (it.pattern_bits[7 - i])
                lvl = it.fg_level;
            else if (it.opaque)
                lvl = it.bg_level;
            else
                continue;
            hit = 1'b0;
            if (it.pack_format == FMT_1BIT) begin
                if ((px >> 1) < COLUMNS && (py >> 2) < ROWS) begin
                    idx  = (px >> 1) * ROWS + (py >> 2);
                    mask = MASK_MSB >> (((py & 3) << 1) + (px & 1));
                    if ((lvl & 1) != 0)
                        frame_model[idx] = frame_model[idx] | mask;
                    else
                        frame_model[idx] = frame_model[idx] & ~mask;
                    hit = 1'b1;
                end
            end else begin
                if (px < COLUMNS && (py >> 1) < ROWS) begin
                    idx = px * ROWS + (py >> 1);
                    if ((py & 1) != 0)
                        frame_model[idx] = (frame_model[idx] & NIB_HI) | 8'(lvl);
                    else
                        frame_model[idx] = (frame_model[idx] & NIB_LO) | 8'(lvl << 4);
                    hit = 1'b1;
                end
            end
            if (hit) begin
                touched_bytes.push_back(idx);
                if (touched_bytes.size() > HOT_DEPTH)
                    void'(touched_bytes.pop_front());
            end
        end
    endfunction

    // drive one transaction, wait for acceptance, then update the model
    task automatic send_request(input span_request_t it);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_func         <= it.func;
        s_pack_format  <= it.pack_format;
        s_span_x       <= it.span_x;
        s_span_y       <= it.span_y;
        s_pattern_bits <= it.pattern_bits;
        s_pixel_count  <= it.pixel_count;
        s_fg_level     <= it.fg_level;
        s_bg_level     <= it.bg_level;
        s_opaque       <= it.opaque;
        s_read_address <= it.read_address;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
        if (it.func == FUNC_READ)
            expected_bytes.push_back((it.read_address < STORE_BYTES) ?
                                     frame_model[it.read_address] : 8'h00);
        else
            paint_span(it);
    endtask

    // every field random over its full width
    function automatic span_request_t noise_request();
        span_request_t it;
        it.func         = 1'($urandom);
        it.pack_format  = 1'($urandom);
        it.span_x       = 9'($urandom);
        it.span_y       = 9'($urandom);
        it.pattern_bits = 8'($urandom);
        it.pixel_count  = 4'($urandom);
        it.fg_level     = 4'($urandom);
        it.bg_level     = 4'($urandom);
        it.opaque       = 1'($urandom);
        it.read_address = 13'($urandom);
        return it;
    endfunction

    function automatic span_request_t span_of(input logic fmt, input int x, input int y,
                                              input int pat, input int cnt, input int fg,
                                              input int bg, input logic opq);
        span_request_t it;
        it              = noise_request();
        it.func         = FUNC_WRITE;
        it.pack_format  = fmt;
        it.span_x       = 9'(x);
        it.span_y       = 9'(y);
        it.pattern_bits = 8'(pat);
        it.pixel_count  = 4'(cnt);
        it.fg_level     = 4'(fg);
        it.bg_level     = 4'(bg);
        it.opaque       = opq;
        return it;
    endfunction

    function automatic span_request_t read_of(input int addr);
        span_request_t it;
        it              = noise_request();
        it.func         = FUNC_READ;
        it.read_address = 13'(addr);
        return it;
    endfunction

    // mostly in-store spans, crowded so that they overlap, some at the far edges
    function automatic span_request_t random_span();
        span_request_t it;
        int unsigned   pick, x_max, y_max;
        it    = noise_request();
        it.func = FUNC_WRITE;
        x_max = (it.pack_format == FMT_4BIT) ? COLUMNS - 1 : 2 * COLUMNS - 1;
        y_max = (it.pack_format == FMT_4BIT) ? 2 * ROWS - 1 : 4 * ROWS - 1;
        pick  = $urandom_range(0, 99);
        if (pick < 45) begin
            it.span_x = 9'($urandom_range(0, 23));
            it.span_y = 9'($urandom_range(0, 15));
        end else if (pick < 55) begin
            it.span_x = 9'($urandom_range(x_max - 10, x_max));
            it.span_y = 9'($urandom_range(y_max - 3, y_max));
        end else if (pick < 88) begin
            it.span_x = 9'($urandom_range(0, x_max));
            it.span_y = 9'($urandom_range(0, y_max));
        end
        pick = $urandom_range(0, 99);
        if (pick < 8)
            it.pixel_count = 4'd0;
        else if (pick < 18)
            it.pixel_count = 4'($urandom_range(9, 15));
        else
            it.pixel_count = 4'($urandom_range(1, 8));
        return it;
    endfunction

    // reads mostly of bytes painted lately
    function automatic span_request_t random_read();
        span_request_t it;
        it = read_of($urandom_range(0, 8191));
        if (touched_bytes.size() != 0 && $urandom_range(0, 3) != 0)
            it.read_address = 13'(touched_bytes[$urandom_range(0, touched_bytes.size() - 1)]);
        return it;
    endfunction

    task automatic run_random_mix(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 40)
                send_request(random_read());
            else
                send_request(random_span());
        end
    endtask

    // field extremes, both packings, saturation, empty spans and edge run-off
    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(read_of(0));
        send_request(read_of(8191));
        send_request(span_of(FMT_1BIT, 0, 0, 8'hff, 8, 1, 0, 1'b0));
        send_request(read_of(0));
        send_request(read_of(3 * ROWS));
        send_request(span_of(FMT_1BIT, 1, 1, 8'haa, 8, 15, 0, 1'b1));
        send_request(read_of(0));
        send_request(read_of(4 * ROWS));
        send_request(span_of(FMT_1BIT, 0, 0, 8'hf0, 4, 14, 15, 1'b0));
        send_request(span_of(FMT_1BIT, 2, 0, 8'h00, 0, 1, 1, 1'b1));
        send_request(read_of(0));
        send_request(read_of(ROWS));
        send_request(span_of(FMT_4BIT, 10, 4, 8'hf0, 8, 15, 5, 1'b1));
        send_request(span_of(FMT_4BIT, 10, 5, 8'hff, 3, 10, 0, 1'b0));
        send_request(read_of(10 * ROWS + 2));
        send_request(read_of(17 * ROWS + 2));
        send_request(span_of(FMT_1BIT, 250, 255, 8'hff, 15, 1, 0, 1'b0));
        send_request(read_of(125 * ROWS + 63));
        send_request(span_of(FMT_4BIT, 124, 127, 8'h5a, 8, 15, 0, 1'b1));
        send_request(read_of(127 * ROWS + 63));
        send_request(span_of(FMT_1BIT, 511, 511, 8'hff, 8, 1, 0, 1'b1));
        send_request(span_of(FMT_4BIT, 200, 0, 8'hff, 8, 15, 15, 1'b1));
        send_request(span_of(FMT_4BIT, 0, 300, 8'hff, 8, 15, 15, 1'b1));
        send_request(read_of(0));
    endtask

    task automatic test_no_idling();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_mix(PHASE_ITEMS);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 53;
        recv_stall_pct = 0;
        run_random_mix(PHASE_ITEMS);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 53;
        run_random_mix(PHASE_ITEMS);
    endtask

    task automatic test_both_idle();
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        run_random_mix(PHASE_ITEMS);
    endtask

    // main sequence
    initial begin
        foreach (frame_model[i])
            frame_model[i] = 8'h00;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_no_idling();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_bytes.size() != 0) begin
            $error("read_data: %0d transactions never arrived", expected_bytes.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
